>>> src/cbs_pkg.sv
`timescale 1ns / 1ps

package cbs_pkg;

    // Fixed field widths
    localparam int PIX_IN_W   = 8;
    localparam int CTR_W      = 9;
    localparam int SUM_W      = 26;
    localparam int RAD_W      = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 2;

    // Parameter defaults
    localparam int DEF_MAX_ROWS   = 512;
    localparam int DEF_MAX_COLS   = 512;
    localparam int DEF_PIXEL_BITS = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_GRID_ROWS = 10'd512;
    localparam logic [CFG_DATA_W-1:0] RST_GRID_COLS = 10'd512;
    localparam logic [RAD_W-1:0]      RST_RADIUS    = 9'd1;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Window corners; bottom-right and top-left add, the other two subtract
    typedef enum logic [1:0] {
        CORNER_BR,
        CORNER_TL,
        CORNER_TR,
        CORNER_BL
    } corner_t;

    typedef struct packed {
        logic                req_type;
        logic [PIX_IN_W-1:0] value_a;
        logic [PIX_IN_W-1:0] value_b;
        logic [CTR_W-1:0]    center_row;
        logic [CTR_W-1:0]    center_col;
    } req_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
    } rsp_item_t;

    typedef struct packed {
        logic    capture;
        logic    ld_read;
        logic    ld_write;
        logic    q_read;
        corner_t corner;
        logic    acc;
        logic    push;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> src/cbs_ram.sv
`timescale 1ns / 1ps

module cbs_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 262144,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/cbs_ctrl.sv
`timescale 1ns / 1ps

module cbs_ctrl
    import cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_type,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       req_stall
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_RD_BR,
        S_Q_RD_TL,
        S_Q_RD_TR,
        S_Q_RD_BL,
        S_Q_ACC,
        S_Q_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    // Decode next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.corner   = CORNER_BR;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (req_type == REQ_QUERY) ? S_Q_RD_BR : S_LD_RD;
                end
            end
            S_LD_RD:
            begin
                cmd.ld_read = 1'b1;
                state_next  = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.ld_write = 1'b1;
                state_next   = S_IDLE;
            end
            S_Q_RD_BR:
            begin
                cmd.q_read = 1'b1;
                cmd.corner = CORNER_BR;
                state_next = S_Q_RD_TL;
            end
            S_Q_RD_TL:
            begin
                cmd.q_read = 1'b1;
                cmd.corner = CORNER_TL;
                cmd.acc    = 1'b1;
                state_next = S_Q_RD_TR;
            end
            S_Q_RD_TR:
            begin
                cmd.q_read = 1'b1;
                cmd.corner = CORNER_TR;
                cmd.acc    = 1'b1;
                state_next = S_Q_RD_BL;
            end
            S_Q_RD_BL:
            begin
                cmd.q_read = 1'b1;
                cmd.corner = CORNER_BL;
                cmd.acc    = 1'b1;
                state_next = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_Q_OUT;
            end
            S_Q_OUT:
            begin
                // Hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    // State and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

endmodule

>>> src/cbs_datapath.sv
`timescale 1ns / 1ps

module cbs_datapath
    import cbs_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  req_item_t             req,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output rsp_item_t             rsp
);

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIM_W   = ($clog2(MAX_DIM + 1) > CFG_DATA_W) ?
                             $clog2(MAX_DIM + 1) : CFG_DATA_W;
    localparam int SW      = DIM_W + 2;
    localparam int RUN_W   = $clog2(MAX_COLS * ((1 << PIX_IN_W) - 1) + 1);
    localparam int ENTRY_W = 2 * SUM_W;
    localparam logic [PIX_IN_W-1:0] PIX_MASK =
        PIX_IN_W'((64'd1 << PIXEL_BITS) - 64'd1);

    // Configuration registers
    logic [CFG_DATA_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [RAD_W-1:0]      radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= RST_GRID_ROWS;
            grid_cols_reg <= RST_GRID_COLS;
            radius_reg    <= RST_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                CFG_RADIUS:    radius_reg    <= cfg_data[RAD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective grid size: zero acts as one, clip to the table size
    logic [DIM_W-1:0] rows_ext, cols_ext, rows_eff, cols_eff;

    always_comb
    begin
        rows_ext = DIM_W'(grid_rows_reg);
        cols_ext = DIM_W'(grid_cols_reg);
        if (rows_ext == '0)
            rows_eff = DIM_W'(1);
        else if (rows_ext > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = rows_ext;
        if (cols_ext == '0)
            cols_eff = DIM_W'(1);
        else if (cols_ext > DIM_W'(MAX_COLS))
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = cols_ext;
    end

    // Load state
    logic [ROW_W-1:0]    load_row_reg;
    logic [COL_W-1:0]    load_col_reg;
    logic [RUN_W-1:0]    run_a_reg, run_b_reg;
    logic [PIX_IN_W-1:0] va_reg, vb_reg;
    logic                above_zero_reg;

    // Wrap the load position before the write
    logic [DIM_W-1:0] lrow_ext, lcol_ext, row_inc, row_w_ext, col_w_ext;
    logic [ROW_W-1:0] row_w, above_row;
    logic [COL_W-1:0] col_w;
    logic [RUN_W-1:0] run_a_sum, run_b_sum;

    always_comb
    begin
        lrow_ext = DIM_W'(load_row_reg);
        lcol_ext = DIM_W'(load_col_reg);
        if (lcol_ext >= cols_eff)
        begin
            col_w_ext = '0;
            row_inc   = lrow_ext + DIM_W'(1);
        end
        else
        begin
            col_w_ext = lcol_ext;
            row_inc   = lrow_ext;
        end
        row_w_ext = (row_inc >= rows_eff) ? '0 : row_inc;
        row_w     = row_w_ext[ROW_W-1:0];
        col_w     = col_w_ext[COL_W-1:0];
        above_row = (row_w == '0) ? '0 : row_w - ROW_W'(1);
        run_a_sum = ((col_w == '0) ? '0 : run_a_reg) + RUN_W'(va_reg);
        run_b_sum = ((col_w == '0) ? '0 : run_b_reg) + RUN_W'(vb_reg);
    end

    // Advance the load position after the write
    logic [DIM_W-1:0] col_nx, row_nx, row_adv, col_adv;

    always_comb
    begin
        col_nx = lcol_ext + DIM_W'(1);
        row_nx = lrow_ext + DIM_W'(1);
        if (col_nx >= cols_eff)
        begin
            col_adv = '0;
            row_adv = (row_nx >= rows_eff) ? '0 : row_nx;
        end
        else
        begin
            col_adv = col_nx;
            row_adv = lrow_ext;
        end
    end

    // Clip the query window at capture
    logic [SW-1:0] cr_ext, cc_ext, rad_ext, r0d, c0d, r1d, c1d;
    logic [SW-1:0] r0c, c0c, r1c, c1c, rlim, clim, r0m1, c0m1;
    logic          win_empty;

    always_comb
    begin
        cr_ext  = SW'(req.center_row);
        cc_ext  = SW'(req.center_col);
        rad_ext = SW'(radius_reg);
        rlim    = SW'(rows_eff) - SW'(1);
        clim    = SW'(cols_eff) - SW'(1);
        r0d     = cr_ext - rad_ext;
        c0d     = cc_ext - rad_ext;
        r1d     = cr_ext + rad_ext;
        c1d     = cc_ext + rad_ext;
        r0c     = r0d[SW-1] ? '0 : r0d;
        c0c     = c0d[SW-1] ? '0 : c0d;
        r1c     = (r1d > rlim) ? rlim : r1d;
        c1c     = (c1d > clim) ? clim : c1d;
        r0m1    = r0c - SW'(1);
        c0m1    = c0c - SW'(1);
        win_empty = (r0c > r1c) || (c0c > c1c);
    end

    logic [ROW_W-1:0] r1_reg, top_row_reg;
    logic [COL_W-1:0] c1_reg, left_col_reg;
    logic             top_zero_reg, left_zero_reg, empty_reg;

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            va_reg        <= req.value_a & PIX_MASK;
            vb_reg        <= req.value_b & PIX_MASK;
            r1_reg        <= r1c[ROW_W-1:0];
            c1_reg        <= c1c[COL_W-1:0];
            top_row_reg   <= (r0c == '0) ? '0 : r0m1[ROW_W-1:0];
            left_col_reg  <= (c0c == '0) ? '0 : c0m1[COL_W-1:0];
            top_zero_reg  <= (r0c == '0);
            left_zero_reg <= (c0c == '0);
            empty_reg     <= win_empty;
        end
    end

    // Pick the corner for a query read
    logic [ROW_W-1:0] q_row;
    logic [COL_W-1:0] q_col;
    logic             q_zero;

    always_comb
    begin
        case (cmd.corner)
            CORNER_BR:
            begin
                q_row  = r1_reg;
                q_col  = c1_reg;
                q_zero = 1'b0;
            end
            CORNER_TL:
            begin
                q_row  = top_row_reg;
                q_col  = left_col_reg;
                q_zero = top_zero_reg || left_zero_reg;
            end
            CORNER_TR:
            begin
                q_row  = top_row_reg;
                q_col  = c1_reg;
                q_zero = top_zero_reg;
            end
            CORNER_BL:
            begin
                q_row  = r1_reg;
                q_col  = left_col_reg;
                q_zero = left_zero_reg;
            end
            default:
            begin
                q_row  = r1_reg;
                q_col  = c1_reg;
                q_zero = 1'b0;
            end
        endcase
    end

    // Select the memory address through one row multiply
    logic [ROW_W-1:0]   mem_row;
    logic [COL_W-1:0]   mem_col;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_rdata, mem_wdata;
    logic [SUM_W-1:0]   above_a, above_b;

    always_comb
    begin
        if (cmd.ld_read)
        begin
            mem_row = above_row;
            mem_col = col_w;
        end
        else if (cmd.ld_write)
        begin
            mem_row = load_row_reg;
            mem_col = load_col_reg;
        end
        else
        begin
            mem_row = q_row;
            mem_col = q_col;
        end
        mem_addr  = ADDR_W'(mem_row) * ADDR_W'(MAX_COLS) + ADDR_W'(mem_col);
        above_a   = above_zero_reg ? '0 : mem_rdata[SUM_W-1:0];
        above_b   = above_zero_reg ? '0 : mem_rdata[ENTRY_W-1:SUM_W];
        mem_wdata = {above_b + SUM_W'(run_b_reg), above_a + SUM_W'(run_a_reg)};
    end

    cbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ld_write),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Load position and row runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            run_a_reg    <= '0;
            run_b_reg    <= '0;
        end
        else if (cmd.ld_read)
        begin
            load_row_reg <= row_w;
            load_col_reg <= col_w;
            run_a_reg    <= run_a_sum;
            run_b_reg    <= run_b_sum;
        end
        else if (cmd.ld_write)
        begin
            load_row_reg <= row_adv[ROW_W-1:0];
            load_col_reg <= col_adv[COL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_read)
        begin
            above_zero_reg <= (row_w == '0);
        end
    end

    // Accumulate the corners
    corner_t          corner_reg;
    logic             czero_reg;
    logic [SUM_W-1:0] acc_a_reg, acc_b_reg, term_a, term_b;
    logic             term_add;

    assign term_a   = czero_reg ? '0 : mem_rdata[SUM_W-1:0];
    assign term_b   = czero_reg ? '0 : mem_rdata[ENTRY_W-1:SUM_W];
    assign term_add = (corner_reg == CORNER_BR) || (corner_reg == CORNER_TL);

    always_ff @(posedge clk)
    begin
        if (cmd.q_read)
        begin
            corner_reg <= cmd.corner;
            czero_reg  <= q_zero;
        end
        if (cmd.capture)
        begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_a_reg <= term_add ? acc_a_reg + term_a : acc_a_reg - term_a;
            acc_b_reg <= term_add ? acc_b_reg + term_b : acc_b_reg - term_b;
        end
    end

    // Output register
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rsp_reg.sum_a <= empty_reg ? '0 : acc_a_reg;
            rsp_reg.sum_b <= empty_reg ? '0 : acc_b_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;
    assign status.out_free = !rsp_valid_reg || !rsp_stall;

endmodule

>>> src/clamped_box_sum_two_channel_core.sv
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake            Beat
// --------  ---------  -------------------  -----------------------------------
// req       in         req_valid/req_stall  req_item_t: load pixel or query
// rsp       out        rsp_valid/rsp_stall  rsp_item_t: sum_a, sum_b
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// A load steps through accept, a read of the entry above and a write; a query
// through accept, four corner reads and the last add on the single table port,
// and push. The single-port summed-area memory makes these steps run in turn.
// Reset clears the controller, the load position, the row runs and the output
// valid flag; the table is not cleared and holds nothing until loaded.
// A query waits in its last step while the previous result is still stalled.
//
module clamped_box_sum_two_channel_core
    import cbs_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_item_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_item_t             rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Take configuration beats at any time
    assign cfg_ready = 1'b1;

    cbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    cbs_datapath #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
